// ----- rtl/mhpq_pkg.sv -----
package mhpq_pkg;

	// Widths of the item fields.
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int SIZE_W   = 11;

	// Link widths, sized for the largest supported heap (65536 entries).
	localparam int IDX_W = 17;
	localparam int POS_W = 16;
	localparam int LVL_W = 5;

	typedef enum logic {
		CMD_INSERT  = 1'b0,
		CMD_EXTRACT = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Kind of token travelling down the row of level cells.
	typedef enum logic [1:0] {
		TK_NONE,
		TK_UP,
		TK_HOLE,
		TK_PARENT
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t          kind;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] carry;
		logic               swapped;
	} tok_t;

	// Write request handed back from a level to the level above it.
	typedef struct packed {
		logic               en;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] data;
	} wb_t;

	// Signals the controller sends to every level.
	typedef struct packed {
		logic               fetch_en;
		logic [IDX_W-1:0]   fetch_idx;
		logic [IDX_W-1:0]   cnt;
		logic [LVL_W-1:0]   lt;
	} bcast_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_ROOT,
		S_LAST,
		S_DOWN,
		S_WAIT,
		S_FIN
	} ctl_st_t;

endpackage

// ----- rtl/mhpq_req_if.sv -----
interface mhpq_req_if import mhpq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic signed [VALUE_W-1:0] insert_value;

	modport source (output valid, output cmd, output insert_value, input ready);
	modport sink (input valid, input cmd, input insert_value, output ready);
endinterface

// ----- rtl/mhpq_rsp_if.sv -----
interface mhpq_rsp_if import mhpq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] out_value;
	logic [STATUS_W-1:0]       status;
	logic [SIZE_W-1:0]         size_after;

	modport source (output valid, output out_value, output status, output size_after,
		input ready);
	modport sink (input valid, input out_value, input status, input size_after,
		output ready);
endinterface

// ----- rtl/mhpq_ram.sv -----
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/mhpq_cell.sv -----
module mhpq_cell import mhpq_pkg::*; #(
	parameter int LVL        = 0,
	parameter int HEAP_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bcast_t             bc,
	input  tok_t               tok_in,
	input  wb_t                wb_in,
	output tok_t               tok_out,
	output wb_t                wb_out,
	output logic [VALUE_W-1:0] fetch_data,
	output logic               done
);

	localparam int BASE      = (1 << LVL) - 1;
	localparam int FULL_SIZE = 1 << LVL;
	localparam int SIZE      = (HEAP_DEPTH - BASE < FULL_SIZE) ? HEAP_DEPTH - BASE : FULL_SIZE;
	localparam int PAIRS     = (SIZE + 1) >> 1;
	localparam int AW        = (PAIRS > 1) ? $clog2(PAIRS) : 1;

	localparam logic [IDX_W-1:0] LVL_IDX    = IDX_W'(BASE);
	localparam logic [IDX_W-1:0] CHILD_BASE = IDX_W'((2 << LVL) - 1);
	localparam logic [LVL_W-1:0] LVL_ID     = LVL_W'(LVL);

	// Entries are held as sibling pairs: lane 0 is the even position, lane 1 the odd one.
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic               we0;
	logic               we1;
	logic [VALUE_W-1:0] wdata;
	logic [VALUE_W-1:0] rd0;
	logic [VALUE_W-1:0] rd1;

	tok_t               cur_q;
	tok_t               tok_q;
	tok_t               tok_d;
	logic               done_q;
	logic               done_d;
	logic               hit_q;
	logic               hit_d;
	logic               lane_q;
	logic               latch;

	logic               own_we;
	logic [POS_W-1:0]   own_pos;
	logic [VALUE_W-1:0] own_data;
	logic               we_any;
	logic [POS_W-1:0]   wpos;

	logic               fhit;
	logic [POS_W-1:0]   fpos;
	logic [IDX_W-1:0]   arr_left;
	logic [IDX_W-1:0]   r_idx;
	logic [IDX_W-1:0]   hole_left;
	logic [POS_W-1:0]   hole_pos;
	logic               pick_r;
	logic [VALUE_W-1:0] pick_v;
	logic               moved;
	logic [VALUE_W-1:0] up_s;
	logic               up_swap;
	logic [LVL_W-1:0]   sh;
	logic [IDX_W-1:0]   m_sh;

	assign fhit = bc.fetch_en && (bc.fetch_idx >= LVL_IDX) && (bc.fetch_idx < CHILD_BASE);
	assign fpos = POS_W'(bc.fetch_idx - LVL_IDX);

	assign arr_left = CHILD_BASE + (IDX_W'(tok_in.pos) << 1);

	// Sibling choice when a parent hole is resolved: right wins ties.
	assign r_idx     = LVL_IDX + (IDX_W'(cur_q.pos) << 1) + IDX_W'(1);
	assign pick_r    = (r_idx < bc.cnt) && ($signed(rd1) <= $signed(rd0));
	assign pick_v    = pick_r ? rd1 : rd0;
	assign moved     = $signed(cur_q.carry) > $signed(pick_v);
	assign hole_pos  = {cur_q.pos[POS_W-2:0], pick_r};
	assign hole_left = CHILD_BASE + (IDX_W'(hole_pos) << 1);

	// Sift-up walks the root-to-target path; the path bit comes from the target's number.
	assign up_s    = cur_q.pos[0] ? rd1 : rd0;
	assign up_swap = cur_q.swapped || ($signed(cur_q.carry) < $signed(up_s));
	assign sh      = bc.lt - LVL_ID - LVL_W'(1);
	assign m_sh    = bc.cnt >> sh;

	always_comb begin
		raddr    = '0;
		own_we   = 1'b0;
		own_pos  = '0;
		own_data = '0;
		tok_d    = '0;
		wb_out   = '0;
		done_d   = 1'b0;
		latch    = 1'b0;
		hit_d    = 1'b0;

		case (tok_in.kind)
			TK_UP: begin
				if (bc.lt == LVL_ID) begin
					own_we   = 1'b1;
					own_pos  = tok_in.pos;
					own_data = tok_in.carry;
					done_d   = 1'b1;
				end else begin
					raddr = AW'(tok_in.pos >> 1);
					latch = 1'b1;
				end
			end
			TK_HOLE: begin
				if (arr_left < bc.cnt) begin
					tok_d      = tok_in;
					tok_d.kind = TK_PARENT;
				end else begin
					own_we   = 1'b1;
					own_pos  = tok_in.pos;
					own_data = tok_in.carry;
					done_d   = 1'b1;
				end
			end
			TK_PARENT: begin
				raddr = AW'(tok_in.pos);
				latch = 1'b1;
			end
			default: begin
			end
		endcase

		if (fhit) begin
			raddr = AW'(fpos >> 1);
			hit_d = 1'b1;
		end

		case (cur_q.kind)
			TK_UP: begin
				if (up_swap) begin
					own_we   = 1'b1;
					own_pos  = cur_q.pos;
					own_data = cur_q.carry;
				end
				tok_d.kind    = TK_UP;
				tok_d.pos     = {cur_q.pos[POS_W-2:0], m_sh[0]};
				tok_d.carry   = up_swap ? up_s : cur_q.carry;
				tok_d.swapped = up_swap;
			end
			TK_PARENT: begin
				wb_out.en   = 1'b1;
				wb_out.pos  = cur_q.pos;
				wb_out.data = moved ? pick_v : cur_q.carry;
				if (!moved) begin
					done_d = 1'b1;
				end else if (hole_left < bc.cnt) begin
					tok_d.kind  = TK_PARENT;
					tok_d.pos   = hole_pos;
					tok_d.carry = cur_q.carry;
				end else begin
					own_we   = 1'b1;
					own_pos  = hole_pos;
					own_data = cur_q.carry;
					done_d   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// The level below only writes back while this level is otherwise quiet.
	assign we_any = own_we || wb_in.en;
	assign wpos   = own_we ? own_pos : wb_in.pos;
	assign wdata  = own_we ? own_data : wb_in.data;
	assign we0    = we_any && !wpos[0];
	assign we1    = we_any && wpos[0];
	assign waddr  = AW'(wpos >> 1);

	mhpq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(PAIRS)
	) u_ram_even (
		.clk  (clk),
		.we   (we0),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd0)
	);

	mhpq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(PAIRS)
	) u_ram_odd (
		.clk  (clk),
		.we   (we1),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			tok_q  <= '0;
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			cur_q  <= latch ? tok_in : '0;
			tok_q  <= tok_d;
			done_q <= done_d;
			hit_q  <= hit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_d) begin
			lane_q <= fpos[0];
		end
	end

	assign tok_out    = tok_q;
	assign done       = done_q;
	assign fetch_data = hit_q ? (lane_q ? rd1 : rd0) : '0;

endmodule

// ----- rtl/min_heap_priority_queue_unit.sv -----
// Binary min-heap priority queue of signed 32-bit values.
// Words arrive on req: cmd 0 inserts insert_value, cmd 1 extracts the minimum.
// Each request word yields exactly one word on rsp carrying out_value (the minimum
// for an extract, otherwise 0), status (ok, extract from empty, insert into full)
// and size_after, the element count after the operation.
// The heap is kept as a row of level cells, one per tree level; each cell owns its
// level's entries in a pair of small RAMs and passes the sift token to the next.
// One operation is in flight at a time. An insert runs down the levels to the one
// the new element lands on. An extract runs until the moved element stops sinking,
// either at a level where it has no children or where no child is smaller. An extract
// that empties the heap skips the sift; a refused insert or extract goes straight to
// the response. At each level passed, a registered RAM read precedes the compare and write.
// A new request can be taken in the same cycle as the response word appears.
// Reset clears the element count and all control state; the heap RAMs are not
// cleared, as only entries below the count are ever read.
// The response sits in an output register; a new request is accepted while it waits,
// and a finished operation holds until the receiver has taken the previous word.
module min_heap_priority_queue_unit import mhpq_pkg::*; #(
	parameter int HEAP_DEPTH = 1024
) (
	input logic       clk,
	input logic       arst_n,
	mhpq_req_if.sink   req,
	mhpq_rsp_if.source rsp
);

	// The count needs as many bits as there are tree levels.
	localparam int CW     = $clog2(HEAP_DEPTH + 1);
	localparam int LEVELS = CW;
	localparam logic [CW-1:0] CNT_FULL = CW'(HEAP_DEPTH);

	ctl_st_t st_q;
	ctl_st_t st_d;

	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      m_new;
	logic [LVL_W-1:0]   lt_q;
	logic [LVL_W-1:0]   lt_new;
	logic [VALUE_W-1:0] val_q;
	logic [VALUE_W-1:0] res_val_q;
	status_t            res_stat_q;

	logic               rsp_valid_q;
	logic [VALUE_W-1:0] rsp_val_q;
	logic [STATUS_W-1:0] rsp_stat_q;
	logic [SIZE_W-1:0]  rsp_size_q;

	logic               req_ready;
	logic               accept;
	logic               cap_root;
	logic               rsp_load;
	logic               full;
	logic               empty;

	bcast_t             bc;
	logic               fetch_en;
	logic [CW-1:0]      fetch_idx;
	tok_t               tok_launch;
	tok_t               tok [1:LEVELS-1];
	wb_t                wb [1:LEVELS-1];
	logic [VALUE_W-1:0] fdata [LEVELS];
	logic [LEVELS-1:0]  done_v;
	logic [VALUE_W-1:0] fetch_or;
	logic               done_any;

	assign full   = (cnt_q == CNT_FULL);
	assign empty  = (cnt_q == '0);
	assign accept = req.valid && req_ready;

	// Depth of the new element: the highest set bit of its one-based number.
	assign m_new = cnt_q + CW'(1);
	always_comb begin
		lt_new = '0;
		for (int b = 0; b < CW; b++) begin
			if (m_new[b]) begin
				lt_new = LVL_W'(b);
			end
		end
	end

	always_comb begin
		fetch_or = '0;
		for (int k = 0; k < LEVELS; k++) begin
			fetch_or = fetch_or | fdata[k];
		end
	end
	assign done_any = |done_v;

	assign bc.fetch_en  = fetch_en;
	assign bc.fetch_idx = IDX_W'(fetch_idx);
	assign bc.cnt       = IDX_W'(cnt_q);
	assign bc.lt        = lt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d       = st_q;
		req_ready  = 1'b0;
		tok_launch = '0;
		fetch_en   = 1'b0;
		fetch_idx  = '0;
		cap_root   = 1'b0;
		rsp_load   = 1'b0;

		case (st_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					if (req.cmd == CMD_INSERT) begin
						st_d = full ? S_FIN : S_UP;
					end else begin
						st_d = empty ? S_FIN : S_ROOT;
					end
				end
			end
			S_UP: begin
				tok_launch.kind  = TK_UP;
				tok_launch.carry = val_q;
				st_d             = S_WAIT;
			end
			S_ROOT: begin
				fetch_en = 1'b1;
				st_d     = S_LAST;
			end
			S_LAST: begin
				// Root word arrives now; the count already excludes it.
				cap_root = 1'b1;
				if (empty) begin
					st_d = S_FIN;
				end else begin
					fetch_en  = 1'b1;
					fetch_idx = cnt_q;
					st_d      = S_DOWN;
				end
			end
			S_DOWN: begin
				tok_launch.kind  = TK_HOLE;
				tok_launch.carry = fetch_or;
				st_d             = S_WAIT;
			end
			S_WAIT: begin
				if (done_any) begin
					st_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					st_d     = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (req.cmd == CMD_INSERT) begin
				if (!full) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else if (!empty) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q     <= req.insert_value;
			lt_q      <= lt_new;
			res_val_q <= '0;
			if (req.cmd == CMD_INSERT) begin
				res_stat_q <= full ? STAT_FULL : STAT_OK;
			end else begin
				res_stat_q <= empty ? STAT_EMPTY : STAT_OK;
			end
		end else if (cap_root) begin
			res_val_q <= fetch_or;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_val_q  <= res_val_q;
			rsp_stat_q <= res_stat_q;
			rsp_size_q <= SIZE_W'(cnt_q);
		end
	end

	assign req.ready      = req_ready;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.out_value  = rsp_val_q;
	assign rsp.status     = rsp_stat_q;
	assign rsp.size_after = rsp_size_q;

	// Level k holds heap indices 2^k - 1 to 2^(k+1) - 2. Tokens go down the row,
	// resolved parent writes come back up one level.
	for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
		if (k == 0) begin : g_top
			mhpq_cell #(
				.LVL       (k),
				.HEAP_DEPTH(HEAP_DEPTH)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.bc        (bc),
				.tok_in    (tok_launch),
				.wb_in     (wb[k + 1]),
				.tok_out   (tok[k + 1]),
				.wb_out    (),
				.fetch_data(fdata[k]),
				.done      (done_v[k])
			);
		end else if (k == LEVELS - 1) begin : g_bottom
			mhpq_cell #(
				.LVL       (k),
				.HEAP_DEPTH(HEAP_DEPTH)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.bc        (bc),
				.tok_in    (tok[k]),
				.wb_in     ('0),
				.tok_out   (),
				.wb_out    (wb[k]),
				.fetch_data(fdata[k]),
				.done      (done_v[k])
			);
		end else begin : g_mid
			mhpq_cell #(
				.LVL       (k),
				.HEAP_DEPTH(HEAP_DEPTH)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.bc        (bc),
				.tok_in    (tok[k]),
				.wb_in     (wb[k + 1]),
				.tok_out   (tok[k + 1]),
				.wb_out    (wb[k]),
				.fetch_data(fdata[k]),
				.done      (done_v[k])
			);
		end
	end

endmodule

// ----- tb/min_heap_priority_queue_unit_tb.sv -----
// Self-checking bench for the min-heap priority queue. Request words are driven
// on req with random gaps, and response words are taken from rsp with random stalls.
// Every accepted request runs through a behavioural heap kept in the bench. That heap, or a
// directed row's literal, gives the expected word, and the receiver checks the answers in order.
module min_heap_priority_queue_unit_tb;
	import mhpq_pkg::*;

	localparam int HEAP_DEPTH = 1024;
	// The receiver holds off for this many cycles during the back-pressure phase.
	localparam int LONG_HOLD  = 300;
	// Time allowed after the last response for any stray word to show up.
	localparam int TAIL_CYCLES = 40;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// One response word, as the block should present it.
	typedef struct packed {
		logic [VALUE_W-1:0] out_value;
		status_t            status;
		logic [SIZE_W-1:0]  size_after;
	} heap_word_t;

	// One row of the directed stimulus. Where use_lit is set, the expected word is
	// written into the row itself. Otherwise the behavioural heap supplies it.
	typedef struct packed {
		cmd_t               op;
		logic [VALUE_W-1:0] val;
		logic               use_lit;
		heap_word_t         lit;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	mhpq_req_if req ();
	mhpq_rsp_if rsp ();

	min_heap_priority_queue_unit #(
		.HEAP_DEPTH(HEAP_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Behavioural copy of the heap. Only entries below heap_count are ever read,
	// so the store needs no clearing.
	logic signed [VALUE_W-1:0] heap_copy [HEAP_DEPTH];
	int unsigned               heap_count;

	// Words predicted but not yet seen on rsp, oldest first.
	heap_word_t expected_words [$];
	stim_row_t  directed_rows [$];

	int error_count;
	int tx_idle_pct;
	int rx_stall_pct;
	int hold_requests;

	// Figures for the closing summary. None of them is checked.
	int words_sent;
	int inserts_seen;
	int extracts_seen;
	int empty_extracts;
	int full_inserts;
	int peak_count;

	// Apply one operation to the behavioural heap and return the word it produces.
	// An insert walks the new value up while it is strictly below its parent. An
	// extract moves the last element to the root and walks it down. At each level
	// the right child wins when it exists and is no greater than the left child, and
	// a swap happens only when the parent is strictly greater than that child.
	function automatic heap_word_t predict_heap_op(input cmd_t op,
		input logic signed [VALUE_W-1:0] val);
		heap_word_t                w;
		int unsigned               pos;
		int unsigned               parent;
		int unsigned               lc;
		int unsigned               rc;
		int unsigned               pick;
		logic signed [VALUE_W-1:0] t;
		bit                        done;
		w.out_value = '0;
		w.status = STAT_OK;
		if (op == CMD_INSERT) begin
			inserts_seen++;
			if (heap_count >= HEAP_DEPTH) begin
				w.status = STAT_FULL;
				full_inserts++;
			end else begin
				pos = heap_count;
				heap_copy[pos] = val;
				done = 1'b0;
				while (pos > 0 && !done) begin
					parent = (pos - 1) / 2;
					if (heap_copy[pos] < heap_copy[parent]) begin
						t = heap_copy[pos];
						heap_copy[pos] = heap_copy[parent];
						heap_copy[parent] = t;
						pos = parent;
					end else begin
						done = 1'b1;
					end
				end
				heap_count++;
			end
		end else begin
			extracts_seen++;
			if (heap_count == 0) begin
				w.status = STAT_EMPTY;
				empty_extracts++;
			end else begin
				w.out_value = heap_copy[0];
				heap_count--;
				heap_copy[0] = heap_copy[heap_count];
				pos = 0;
				done = 1'b0;
				while (!done) begin
					lc = 2 * pos + 1;
					rc = 2 * pos + 2;
					if (rc < heap_count && heap_copy[rc] <= heap_copy[lc]) begin
						pick = rc;
					end else if (lc < heap_count) begin
						pick = lc;
					end else begin
						done = 1'b1;
					end
					if (!done) begin
						if (heap_copy[pos] > heap_copy[pick]) begin
							t = heap_copy[pos];
							heap_copy[pos] = heap_copy[pick];
							heap_copy[pick] = t;
							pos = pick;
						end else begin
							done = 1'b1;
						end
					end
				end
			end
		end
		if (heap_count > peak_count) begin
			peak_count = heap_count;
		end
		w.size_after = heap_count[SIZE_W-1:0];
		return w;
	endfunction

	// Values lean on ties and on the two extremes. Equal keys are what decide
	// between the left and the right child, and between swapping and stopping.
	function automatic logic [VALUE_W-1:0] random_value();
		case ($urandom_range(9))
			0, 1: begin
				return $urandom_range(4) - 2;
			end
			2: begin
				return 32'h7FFF_FFFF;
			end
			3: begin
				return 32'h8000_0000;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			IDLE_SENDER: begin
				tx_idle_pct = 85;
				rx_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				tx_idle_pct = 0;
				rx_stall_pct = 85;
			end
			default: begin
				tx_idle_pct = 34;
				rx_stall_pct = 34;
			end
		endcase
	endtask

	// Offer one request word and wait until the block takes it. Valid is left high on
	// return. The next word either replaces the payload or lowers valid for a gap, so
	// valid gets only one assignment in any time step.
	task automatic offer_word(input cmd_t op, input logic [VALUE_W-1:0] val,
		input logic use_lit, input heap_word_t lit);
		heap_word_t predicted;
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= op;
		req.insert_value <= val;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		predicted = predict_heap_op(op, val);
		expected_words.push_back(use_lit ? lit : predicted);
		words_sent++;
	endtask

	task automatic offer_random(input int insert_pct);
		cmd_t op;
		op = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
		offer_word(op, random_value(), 1'b0, '0);
	endtask

	// Stop offering and wait until every predicted word has come back.
	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic add_row(input cmd_t op, input logic [VALUE_W-1:0] val,
		input logic use_lit, input logic [VALUE_W-1:0] want_value,
		input status_t want_status, input logic [SIZE_W-1:0] want_size);
		stim_row_t r;
		r.op = op;
		r.val = val;
		r.use_lit = use_lit;
		r.lit.out_value = want_value;
		r.lit.status = want_status;
		r.lit.size_after = want_size;
		directed_rows.push_back(r);
	endtask

	task automatic check_word();
		heap_word_t want;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected word out_value=%0d status=%0d size_after=%0d",
				$time, rsp.out_value, rsp.status, rsp.size_after);
			error_count++;
		end else begin
			want = expected_words.pop_front();
			if (rsp.out_value !== want.out_value) begin
				$display("%0t: out_value expected %0d got %0d", $time,
					$signed(want.out_value), rsp.out_value);
				error_count++;
			end
			if (rsp.status !== want.status) begin
				$display("%0t: status expected %0d got %0d", $time, want.status,
					rsp.status);
				error_count++;
			end
			if (rsp.size_after !== want.size_after) begin
				$display("%0t: size_after expected %0d got %0d", $time,
					want.size_after, rsp.size_after);
				error_count++;
			end
		end
	endtask

	// Receiver. At each rising edge it checks any word taken at that edge. It then
	// decides ready for the next cycle. A request for a long hold-off is spotted as a
	// change in hold_requests and counted down here, in this process alone.
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				check_word();
			end
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Watchdog. It ends a run that hangs.
	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int i;
		int n;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_INSERT;
		req.insert_value = '0;
		heap_count = 0;
		error_count = 0;
		hold_requests = 0;
		words_sent = 0;
		inserts_seen = 0;
		extracts_seen = 0;
		empty_extracts = 0;
		full_inserts = 0;
		peak_count = 0;
		set_idling(IDLE_NONE);

		// Directed rows. The first few rows pin down the empty-heap extract and the
		// two extremes passing straight through. Three equal values then test the tie
		// rules. Extremes, zero and small keys follow, and the heap is then emptied
		// again. An extract on a heap of three entries reaches a node with
		// only a left child.
		add_row(CMD_EXTRACT, 32'd0,         1'b1, 32'd0,         STAT_EMPTY, 11'd0);
		add_row(CMD_INSERT,  32'h7FFF_FFFF, 1'b1, 32'd0,         STAT_OK,    11'd1);
		add_row(CMD_EXTRACT, 32'd0,         1'b1, 32'h7FFF_FFFF, STAT_OK,    11'd0);
		add_row(CMD_INSERT,  32'h8000_0000, 1'b1, 32'd0,         STAT_OK,    11'd1);
		add_row(CMD_EXTRACT, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, STAT_OK,    11'd0);
		add_row(CMD_EXTRACT, 32'd0,         1'b1, 32'd0,         STAT_EMPTY, 11'd0);
		add_row(CMD_INSERT,  32'd5,         1'b0, '0, STAT_OK, '0);
		add_row(CMD_INSERT,  32'd5,         1'b0, '0, STAT_OK, '0);
		add_row(CMD_INSERT,  32'd5,         1'b0, '0, STAT_OK, '0);
		add_row(CMD_INSERT,  32'hFFFF_FFFD, 1'b0, '0, STAT_OK, '0);
		add_row(CMD_INSERT,  32'h7FFF_FFFF, 1'b0, '0, STAT_OK, '0);
		add_row(CMD_INSERT,  32'h8000_0000, 1'b0, '0, STAT_OK, '0);
		add_row(CMD_INSERT,  32'd0,         1'b0, '0, STAT_OK, '0);
		add_row(CMD_INSERT,  32'hFFFF_FFFF, 1'b0, '0, STAT_OK, '0);
		add_row(CMD_INSERT,  32'd1,         1'b0, '0, STAT_OK, '0);
		for (i = 0; i < 9; i++) begin
			add_row(CMD_EXTRACT, 32'd0, 1'b0, '0, STAT_OK, '0);
		end
		add_row(CMD_EXTRACT, 32'd0,         1'b1, 32'd0,         STAT_EMPTY, 11'd0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			offer_word(directed_rows[k].op, directed_rows[k].val,
				directed_rows[k].use_lit, directed_rows[k].lit);
		end
		wait_drained();

		// Mixed traffic on a shallow heap, once under each idling pattern.
		set_idling(IDLE_NONE);
		for (i = 0; i < 80; i++) offer_random(60);
		set_idling(IDLE_SENDER);
		for (i = 0; i < 80; i++) offer_random(50);
		set_idling(IDLE_RECEIVER);
		for (i = 0; i < 80; i++) offer_random(55);
		set_idling(IDLE_BOTH);
		for (i = 0; i < 80; i++) offer_random(50);

		// Back-pressure. The receiver holds off for a long stretch while the sender
		// keeps offering words, so the output register fills and req.ready drops.
		// The sender then pauses until every word has come back.
		set_idling(IDLE_NONE);
		hold_requests++;
		for (i = 0; i < 30; i++) offer_random(60);
		wait_drained();

		// Fill the heap to its limit. Sifts now run the full depth of the tree.
		// Inserts on the full heap must be refused. The heap is then filled again
		// after a single extract.
		while (heap_count < HEAP_DEPTH) offer_random(95);
		for (i = 0; i < 6; i++) offer_word(CMD_INSERT, random_value(), 1'b0, '0);
		offer_word(CMD_EXTRACT, '0, 1'b0, '0);
		offer_word(CMD_INSERT, random_value(), 1'b0, '0);
		offer_word(CMD_INSERT, random_value(), 1'b0, '0);

		// Drain from a deep heap, passing once through each idling pattern.
		for (n = 0; n < 4; n++) begin
			set_idling(idle_mode_t'(n));
			for (i = 0; i < 40; i++) offer_random(30);
		end

		set_idling(IDLE_NONE);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d words: %0d inserts (%0d refused as full), %0d extracts",
			words_sent, inserts_seen, full_inserts, extracts_seen);
		$display("(%0d on an empty heap); heap held at most %0d entries.",
			empty_extracts, peak_count);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/mhpq_pkg.sv
rtl/mhpq_req_if.sv
rtl/mhpq_rsp_if.sv
rtl/mhpq_ram.sv
rtl/mhpq_cell.sv
rtl/min_heap_priority_queue_unit.sv
tb/min_heap_priority_queue_unit_tb.sv
